>>> sv/timed_pwm_update_queue_with_watchdog_unit_macros.svh
// Assertion helpers for the file that carries checks.
`ifndef TIMED_PWM_UPDATE_QUEUE_WITH_WATCHDOG_UNIT_MACROS_SVH
`define TIMED_PWM_UPDATE_QUEUE_WITH_WATCHDOG_UNIT_MACROS_SVH

// General property on clk, masked while reset is asserted
`define TWPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define TWPQ_ASSERT_IMPL(label, ante, cons, msg) \
    `TWPQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> sv/twpq_pkg.sv
`timescale 1ns / 1ps

package twpq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int LEVEL_W = 5;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAFE_DUTY  = 1'd0,
        REG_HOLD_LIMIT = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_QUEUE    = 2'd0,
        OP_TICK     = 2'd1,
        OP_SHUTDOWN = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        FC_NONE     = 2'd0,
        FC_TIMEOUT  = 2'd1,
        FC_HOLD     = 2'd2,
        FC_OVERFLOW = 2'd3
    } fault_code_t;

    // Input word
    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] event_time;
        logic [DUTY_W-1:0] duty_in;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [DUTY_W-1:0]  pwm_duty;
        logic               duty_written;
        logic               fault;
        logic [1:0]         fault_code;
        logic [LEVEL_W-1:0] queue_level;
    } out_item_t;

    // Queue control from the sequencer
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [TIME_W-1:0] push_time;
        logic [DUTY_W-1:0] push_duty;
    } fifo_cmd_t;

    // Queue status back to the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DUTY_W-1:0]  head_duty;
        logic [TIME_W-1:0]  next_time;
    } fifo_status_t;

endpackage

>>> sv/twpq_fifo.sv
`timescale 1ns / 1ps

// Shifting queue: the head always sits in entry 0, the one behind it in entry 1.
module twpq_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  twpq_pkg::fifo_cmd_t   cmd,
    output twpq_pkg::fifo_status_t status
);

    logic [twpq_pkg::TIME_W-1:0]  time_mem [twpq_pkg::QUEUE_DEPTH];
    logic [twpq_pkg::DUTY_W-1:0]  duty_mem [twpq_pkg::QUEUE_DEPTH];
    logic [twpq_pkg::COUNT_W-1:0] count_reg;
    logic [twpq_pkg::COUNT_W-1:0] count_next;

    // Entry storage: append at the tail, shift towards the head on a pop
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            time_mem[count_reg[twpq_pkg::IDX_W-1:0]] <= cmd.push_time;
            duty_mem[count_reg[twpq_pkg::IDX_W-1:0]] <= cmd.push_duty;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < twpq_pkg::QUEUE_DEPTH - 1; i++)
            begin
                time_mem[i] <= time_mem[i+1];
                duty_mem[i] <= duty_mem[i+1];
            end
        end
    end

    // Fill level
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.push)
            count_next = count_reg + twpq_pkg::COUNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - twpq_pkg::COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign status.count     = count_reg;
    assign status.head_duty = duty_mem[0];
    assign status.next_time = time_mem[1];

endmodule

>>> sv/twpq_ctrl.sv
`timescale 1ns / 1ps

// Alarm, watchdog and fault sequencing; one registered item in, one result out.
module twpq_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  twpq_pkg::in_item_t            item,
    input  logic [twpq_pkg::DUTY_W-1:0]   safe_duty,
    input  logic [twpq_pkg::TIME_W-1:0]   hold_limit,
    input  twpq_pkg::fifo_status_t        fifo_st,
    output twpq_pkg::fifo_cmd_t           fifo_cmd,
    output logic                          done,
    output twpq_pkg::out_item_t           result
);

    // a is before b under the wrapping signed difference
    function automatic logic is_before(input logic [twpq_pkg::TIME_W-1:0] a,
                                       input logic [twpq_pkg::TIME_W-1:0] b);
        logic [twpq_pkg::TIME_W-1:0] diff;
        begin
            diff = a - b;
            return diff[twpq_pkg::TIME_W-1];
        end
    endfunction

    logic [twpq_pkg::TIME_W-1:0] alarm_time_reg, alarm_time_next;
    logic                        alarm_armed_reg, alarm_armed_next;
    logic                        alarm_timeout_reg, alarm_timeout_next;
    logic [twpq_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic                        fault_reg, fault_next;
    twpq_pkg::fault_code_t       fault_code_reg, fault_code_next;
    logic                        done_reg;
    twpq_pkg::out_item_t         result_reg, result_next;

    logic                        go_safe;
    twpq_pkg::fault_code_t       safe_code;
    logic                        push, pop, written;
    logic                        q_empty, q_full, q_last;
    logic [twpq_pkg::TIME_W-1:0] deadline;
    logic [twpq_pkg::COUNT_W-1:0] level_next;

    assign q_empty  = (fifo_st.count == '0);
    assign q_full   = (fifo_st.count == twpq_pkg::COUNT_W'(twpq_pkg::QUEUE_DEPTH));
    assign q_last   = (fifo_st.count == twpq_pkg::COUNT_W'(1));
    assign deadline = alarm_time_reg + hold_limit;

    // Item decode and next state
    always_comb
    begin
        alarm_time_next    = alarm_time_reg;
        alarm_armed_next   = alarm_armed_reg;
        alarm_timeout_next = alarm_timeout_reg;
        duty_next          = duty_reg;
        fault_next         = fault_reg;
        fault_code_next    = fault_code_reg;
        go_safe            = 1'b0;
        safe_code          = twpq_pkg::FC_NONE;
        push               = 1'b0;
        pop                = 1'b0;
        written            = 1'b0;

        if (in_valid)
        begin
            case (item.opcode)
                twpq_pkg::OP_SHUTDOWN:
                begin
                    go_safe   = 1'b1;
                    safe_code = twpq_pkg::FC_NONE;
                end
                twpq_pkg::OP_QUEUE:
                begin
                    if (!fault_reg)
                    begin
                        if (q_full)
                        begin
                            go_safe   = 1'b1;
                            safe_code = twpq_pkg::FC_OVERFLOW;
                        end
                        else
                        begin
                            push = 1'b1;
                            // first entry into an empty queue sets the alarm
                            if (q_empty)
                            begin
                                if (alarm_armed_reg && alarm_timeout_reg
                                    && is_before(alarm_time_reg, item.event_time))
                                begin
                                    go_safe   = 1'b1;
                                    safe_code = twpq_pkg::FC_HOLD;
                                end
                                else
                                begin
                                    alarm_time_next    = item.event_time;
                                    alarm_armed_next   = 1'b1;
                                    alarm_timeout_next = 1'b0;
                                end
                            end
                        end
                    end
                end
                twpq_pkg::OP_TICK:
                begin
                    if (!fault_reg && alarm_armed_reg
                        && !is_before(item.event_time, alarm_time_reg))
                    begin
                        if (alarm_timeout_reg)
                        begin
                            go_safe   = 1'b1;
                            safe_code = twpq_pkg::FC_TIMEOUT;
                        end
                        else if (q_empty)
                            alarm_armed_next = 1'b0;
                        else
                        begin
                            pop       = 1'b1;
                            written   = 1'b1;
                            duty_next = fifo_st.head_duty;
                            if (q_last)
                            begin
                                // queue drained: watchdog unless safe or disabled
                                if (fifo_st.head_duty == safe_duty || hold_limit == '0)
                                    alarm_armed_next = 1'b0;
                                else
                                begin
                                    alarm_time_next    = deadline;
                                    alarm_timeout_next = 1'b1;
                                end
                            end
                            else if (fifo_st.head_duty != safe_duty && hold_limit != '0
                                     && is_before(deadline, fifo_st.next_time))
                            begin
                                go_safe   = 1'b1;
                                safe_code = twpq_pkg::FC_HOLD;
                            end
                            else
                                alarm_time_next = fifo_st.next_time;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Safe state overrides everything above
        if (go_safe)
        begin
            written            = 1'b1;
            duty_next          = safe_duty;
            alarm_armed_next   = 1'b0;
            alarm_timeout_next = 1'b0;
            if (!fault_reg)
            begin
                fault_next      = 1'b1;
                fault_code_next = safe_code;
            end
        end
    end

    // Queue commands; a clear wins over push and pop
    assign fifo_cmd.push      = push && !go_safe;
    assign fifo_cmd.pop       = pop && !go_safe;
    assign fifo_cmd.clear     = go_safe;
    assign fifo_cmd.push_time = item.event_time;
    assign fifo_cmd.push_duty = item.duty_in;

    always_comb
    begin
        if (go_safe)
            level_next = '0;
        else if (push)
            level_next = fifo_st.count + twpq_pkg::COUNT_W'(1);
        else if (pop)
            level_next = fifo_st.count - twpq_pkg::COUNT_W'(1);
        else
            level_next = fifo_st.count;
    end

    // Result word
    always_comb
    begin
        result_next.pwm_duty     = duty_next;
        result_next.duty_written = written;
        result_next.fault        = fault_next;
        result_next.fault_code   = fault_code_next;
        result_next.queue_level  = twpq_pkg::LEVEL_W'(level_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_time_reg    <= '0;
            alarm_armed_reg   <= 1'b0;
            alarm_timeout_reg <= 1'b0;
            duty_reg          <= '0;
            fault_reg         <= 1'b0;
            fault_code_reg    <= twpq_pkg::FC_NONE;
            done_reg          <= 1'b0;
        end
        else
        begin
            alarm_time_reg    <= alarm_time_next;
            alarm_armed_reg   <= alarm_armed_next;
            alarm_timeout_reg <= alarm_timeout_next;
            duty_reg          <= duty_next;
            fault_reg         <= fault_next;
            fault_code_reg    <= fault_code_next;
            done_reg          <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/timed_pwm_update_queue_with_watchdog_unit.sv
`timescale 1ns / 1ps

// Timed PWM update queue with watchdog. A command word (queue update, time tick
// or shutdown) is taken on any cycle with start high; busy never rises, so one
// word can be issued every clock. Each word yields exactly one result, shown on
// result for a single cycle with done high: it passes one input register, then
// the sequencer and queue update, then the result register. The result cannot be
// held off, so it must be captured in the cycle done is high. The 16-entry queue
// is a shifting register file, read at its head and the entry behind it. Write
// safe_duty and hold_limit only while no word is in flight.
`include "timed_pwm_update_queue_with_watchdog_unit_macros.svh"

module timed_pwm_update_queue_with_watchdog_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  twpq_pkg::in_item_t                item,
    input  logic                              cfg_we,
    input  logic [twpq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [twpq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                              done,
    output twpq_pkg::out_item_t               result
);

    logic                          in_valid_reg;
    twpq_pkg::in_item_t            item_reg;
    logic [twpq_pkg::DUTY_W-1:0]   safe_duty_reg;
    logic [twpq_pkg::TIME_W-1:0]   hold_limit_reg;
    twpq_pkg::fifo_cmd_t           fifo_cmd;
    twpq_pkg::fifo_status_t        fifo_st;

    assign busy = 1'b0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_duty_reg  <= '0;
            hold_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                twpq_pkg::REG_SAFE_DUTY:
                    safe_duty_reg <= cfg_wdata[twpq_pkg::DUTY_W-1:0];
                twpq_pkg::REG_HOLD_LIMIT:
                    hold_limit_reg <= cfg_wdata[twpq_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    twpq_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (fifo_cmd),
        .status (fifo_st)
    );

    twpq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .item       (item_reg),
        .safe_duty  (safe_duty_reg),
        .hold_limit (hold_limit_reg),
        .fifo_st    (fifo_st),
        .fifo_cmd   (fifo_cmd),
        .done       (done),
        .result     (result)
    );

    // Checks
    `TWPQ_ASSERT(a_result_latency, (start && !busy) |-> ##2 done, "word taken without a result")
    `TWPQ_ASSERT_IMPL(a_fault_empties, done && result.fault, result.queue_level == '0, "queue not empty while faulted")
    `TWPQ_ASSERT_IMPL(a_code_needs_fault, done && !result.fault, result.fault_code == twpq_pkg::FC_NONE, "fault code without fault")
    `TWPQ_ASSERT_IMPL(a_no_push_full, fifo_cmd.push, fifo_st.count < twpq_pkg::COUNT_W'(twpq_pkg::QUEUE_DEPTH), "push into full queue")

endmodule
